// ===== design/fawcl_pkg.sv =====
// ============================================================================
// fawcl_pkg: shared types and constants of the fire alarm with code lock
// Holds the alarm modes, the key codes, the register indexes, the code
// length limits and the power-up code.
// ============================================================================
package fawcl_pkg;

    // Longest code that can be stored or typed.
    localparam int MAX_DIGITS = 9;
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // Field widths of the channels.
    localparam int TEMP_W     = 12;
    localparam int SMOKE_W    = 10;
    localparam int KEY_W      = 8;
    localparam int DIGIT_W    = 4;
    localparam int NVM_ADDR_W = 4;
    localparam int CFG_DATA_W = 12;

    // The power-up code is "4321", cut short if the code store is smaller.
    localparam int INIT_LEN   = (MAX_DIGITS < 4) ? MAX_DIGITS : 4;

    typedef enum logic [1:0] {
        MODE_FINE = 2'd0,
        MODE_HEAT = 2'd1,
        MODE_FIRE = 2'd2
    } mode_t;

    typedef enum logic {
        CMD_SENSOR = 1'b0,
        CMD_KEY    = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        REG_HEAT_ON  = 2'd0,
        REG_HEAT_OFF = 2'd1,
        REG_SMOKE    = 2'd2
    } cfg_index_t;

    localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
    localparam logic [KEY_W-1:0] KEY_ONE   = 8'h31;
    localparam logic [KEY_W-1:0] KEY_TWO   = 8'h32;
    localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;
    localparam logic [KEY_W-1:0] KEY_EQUAL = 8'h3D;

    localparam logic [TEMP_W-1:0]  HEAT_ON_RESET  = 12'd500;
    localparam logic [TEMP_W-1:0]  HEAT_OFF_RESET = 12'd450;
    localparam logic [SMOKE_W-1:0] SMOKE_RESET    = 10'd50;

    // Digit of the power-up code at a given position, zero past its end.
    function automatic logic [DIGIT_W-1:0] init_digit(input int pos);
        logic [DIGIT_W-1:0] digit;
        digit = '0;
        if (pos < INIT_LEN)
        begin
            digit = DIGIT_W'(4 - pos);
        end
        return digit;
    endfunction

endpackage

// ===== design/fire_alarm_with_code_lock.sv =====
// ============================================================================
// fire_alarm_with_code_lock: alarm state machine with a numeric code lock
// Tracks heat and fire from sensor ticks and handles code entry and code
// change from key presses, one result per input transfer.
// ============================================================================
// Usage:
// Each transfer on the item channel (item_valid high, item_stall low) is
// either a sensor tick (command 0: temperature and smoke_level are used) or
// a key press (command 1: key_code is used). Every item produces exactly one
// transfer on the result channel, carrying the alarm state after the item,
// the lamp and status levels, the wrong_code / code_accepted pulses and an
// optional byte write request for the nonvolatile code store.
// An item is captured in an input register, evaluated by one pass of logic
// against the alarm state, and lands in a result register, from which the
// result is offered. One item is taken every cycle while item_stall is low;
// the rate is set only by the single evaluation step that updates the state.
// When result_stall is high the result register holds; the input register
// still fills, and item_stall rises only once both stages are occupied.
// The config channel (cfg_valid, cfg_ready always high) writes the two
// temperature levels and the smoke limit; writes are meant for idle times.
// Reset clears the state to fine with the code "4321" and the default levels.
// ============================================================================
module fire_alarm_with_code_lock (
    input  logic                               clk,
    input  logic                               rst_n,
    // item channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               command,
    input  logic [fawcl_pkg::TEMP_W-1:0]       temperature,
    input  logic [fawcl_pkg::SMOKE_W-1:0]      smoke_level,
    input  logic [fawcl_pkg::KEY_W-1:0]        key_code,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [1:0]                         alarm_state,
    output logic                               heat_lamp,
    output logic                               fire_alarm,
    output logic                               entry_active,
    output logic                               change_active,
    output logic                               wrong_code,
    output logic                               code_accepted,
    output logic                               nvm_write,
    output logic [fawcl_pkg::NVM_ADDR_W-1:0]   nvm_address,
    output logic [fawcl_pkg::KEY_W-1:0]        nvm_data,
    // configuration channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  fawcl_pkg::cfg_index_t              cfg_index,
    input  logic [fawcl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fawcl_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TEMP_W-1:0]  heat_on_reg;
    logic [TEMP_W-1:0]  heat_off_reg;
    logic [SMOKE_W-1:0] smoke_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_on_reg     <= HEAT_ON_RESET;
            heat_off_reg    <= HEAT_OFF_RESET;
            smoke_limit_reg <= SMOKE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HEAT_ON:  heat_on_reg     <= cfg_data[TEMP_W-1:0];
                REG_HEAT_OFF: heat_off_reg    <= cfg_data[TEMP_W-1:0];
                REG_SMOKE:    smoke_limit_reg <= cfg_data[SMOKE_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register feeds the result register.
    // ------------------------------------------------------------------
    logic               in_valid_reg;
    command_t           in_command_reg;
    logic [TEMP_W-1:0]  in_temp_reg;
    logic [SMOKE_W-1:0] in_smoke_reg;
    logic [KEY_W-1:0]   in_key_reg;
    logic               out_valid_reg;
    logic               out_free;
    logic               go;

    // The result register can take a new value when it is empty or when its
    // current result is transferred in this cycle.
    assign out_free   = !out_valid_reg || !result_stall;
    assign go         = in_valid_reg && out_free;
    assign item_stall = in_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_command_reg <= command_t'(command);
            in_temp_reg    <= temperature;
            in_smoke_reg   <= smoke_level;
            in_key_reg     <= key_code;
        end
    end

    // ------------------------------------------------------------------
    // Alarm and lock state
    // ------------------------------------------------------------------
    mode_t              mode_reg,          mode_next;
    logic               lamp_reg,          lamp_next;
    logic               fire_reg,          fire_next;
    logic               entering_reg,      entering_next;
    logic               changing_reg,      changing_next;
    logic [CNT_W-1:0]   stored_len_reg,    stored_len_next;
    logic [CNT_W-1:0]   typed_count_reg,   typed_count_next;
    logic [CNT_W-1:0]   change_index_reg,  change_index_next;
    logic [DIGIT_W-1:0] stored_code_reg [MAX_DIGITS];
    logic [DIGIT_W-1:0] typed_digits_reg [MAX_DIGITS];

    // ------------------------------------------------------------------
    // Decode of the item under evaluation
    // ------------------------------------------------------------------
    logic               is_sensor;
    logic               is_key;
    logic               hot;
    logic               cool;
    logic               smoky;
    logic               key_is_digit;
    logic [DIGIT_W-1:0] key_digit;
    logic               entry_start;
    logic               entry_digit;
    logic               entry_submit;
    logic               typed_room;
    logic               change_start;
    logic               change_digit;
    logic               change_end;
    logic               codes_match;

    always_comb
    begin
        is_sensor    = (in_command_reg == CMD_SENSOR);
        is_key       = (in_command_reg == CMD_KEY);
        hot          = (in_temp_reg > heat_on_reg);
        cool         = (in_temp_reg < heat_off_reg);
        smoky        = (in_smoke_reg > smoke_limit_reg);
        key_is_digit = (in_key_reg >= KEY_ZERO) && (in_key_reg <= KEY_NINE);
        key_digit    = DIGIT_W'(in_key_reg - KEY_ZERO);

        // Code entry runs in fire, or stays open once started.
        entry_start  = is_key && (mode_reg == MODE_FIRE) && !entering_reg
                       && (in_key_reg == KEY_ONE);
        entry_digit  = is_key && entering_reg && key_is_digit;
        entry_submit = is_key && entering_reg && (in_key_reg == KEY_EQUAL);
        typed_room   = (typed_count_reg < CNT_W'(MAX_DIGITS));

        // Code change opens only outside fire; digits past the limit are dropped.
        change_start = is_key && !changing_reg && (in_key_reg == KEY_TWO)
                       && ((mode_reg == MODE_FINE) || (mode_reg == MODE_HEAT));
        change_digit = is_key && changing_reg && key_is_digit
                       && (change_index_reg < CNT_W'(MAX_DIGITS));
        change_end   = is_key && changing_reg && (in_key_reg == KEY_EQUAL);

        // Lengths must agree, and every typed position must match.
        codes_match = (typed_count_reg == stored_len_reg);
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if ((CNT_W'(i) < typed_count_reg) &&
                (typed_digits_reg[i] != stored_code_reg[i]))
            begin
                codes_match = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next         = mode_reg;
        lamp_next         = lamp_reg;
        fire_next         = fire_reg;
        entering_next     = entering_reg;
        changing_next     = changing_reg;
        stored_len_next   = stored_len_reg;
        typed_count_next  = typed_count_reg;
        change_index_next = change_index_reg;

        if (is_sensor)
        begin
            if (mode_reg != MODE_FIRE)
            begin
                if (hot)
                begin
                    mode_next = MODE_HEAT;
                    lamp_next = 1'b1;
                end
                else if (cool)
                begin
                    mode_next = MODE_FINE;
                    lamp_next = 1'b0;
                end
            end
            // Fire latches; the heat lamp keeps its level from that moment.
            if (hot && smoky)
            begin
                mode_next = MODE_FIRE;
                fire_next = 1'b1;
            end
        end

        if (entry_start)
        begin
            entering_next    = 1'b1;
            typed_count_next = '0;
        end
        else if (entry_digit && typed_room)
        begin
            typed_count_next = typed_count_reg + 1'b1;
        end
        else if (entry_submit)
        begin
            if (codes_match)
            begin
                mode_next = MODE_FINE;
                lamp_next = 1'b0;
                fire_next = 1'b0;
            end
            entering_next    = 1'b0;
            typed_count_next = '0;
        end

        if (change_start)
        begin
            changing_next     = 1'b1;
            change_index_next = '0;
        end
        else if (change_digit)
        begin
            change_index_next = change_index_reg + 1'b1;
        end
        else if (change_end)
        begin
            stored_len_next   = change_index_reg;
            changing_next     = 1'b0;
            change_index_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // Result fields
    // ------------------------------------------------------------------
    logic                  wrong_next;
    logic                  accepted_next;
    logic                  nvm_write_next;
    logic [NVM_ADDR_W-1:0] nvm_address_next;
    logic [KEY_W-1:0]      nvm_data_next;

    always_comb
    begin
        wrong_next       = entry_submit && !codes_match;
        accepted_next    = entry_submit && codes_match;
        nvm_write_next   = 1'b0;
        nvm_address_next = '0;
        nvm_data_next    = '0;
        if (change_digit)
        begin
            nvm_write_next   = 1'b1;
            nvm_address_next = NVM_ADDR_W'(change_index_reg);
            nvm_data_next    = in_key_reg;
        end
        else if (change_end)
        begin
            // A zero byte terminates the stored code.
            nvm_write_next   = 1'b1;
            nvm_address_next = NVM_ADDR_W'(change_index_reg);
        end
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_FINE;
            lamp_reg         <= 1'b0;
            fire_reg         <= 1'b0;
            entering_reg     <= 1'b0;
            changing_reg     <= 1'b0;
            stored_len_reg   <= CNT_W'(INIT_LEN);
            typed_count_reg  <= '0;
            change_index_reg <= '0;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                stored_code_reg[i] <= init_digit(i);
            end
        end
        else if (go)
        begin
            mode_reg         <= mode_next;
            lamp_reg         <= lamp_next;
            fire_reg         <= fire_next;
            entering_reg     <= entering_next;
            changing_reg     <= changing_next;
            stored_len_reg   <= stored_len_next;
            typed_count_reg  <= typed_count_next;
            change_index_reg <= change_index_next;
            if (change_digit)
            begin
                stored_code_reg[change_index_reg[IDX_W-1:0]] <= key_digit;
            end
        end
    end

    // The typed digits are only ever read below the typed count.
    always_ff @(posedge clk)
    begin
        if (go && entry_digit && typed_room)
        begin
            typed_digits_reg[typed_count_reg[IDX_W-1:0]] <= key_digit;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            alarm_state   <= mode_next;
            heat_lamp     <= lamp_next;
            fire_alarm    <= fire_next;
            entry_active  <= entering_next;
            change_active <= changing_next;
            wrong_code    <= wrong_next;
            code_accepted <= accepted_next;
            nvm_write     <= nvm_write_next;
            nvm_address   <= nvm_address_next;
            nvm_data      <= nvm_data_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule
